// File: rtl/core/gnss_binary_frame_parser_defines.svh
// ----------------------------------------------------------------------------
// GNSS binary frame parser assertion macros
// Concurrent assertion helpers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef GNSS_BINARY_FRAME_PARSER_DEFINES_SVH
`define GNSS_BINARY_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTH
`define GBFP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define GBFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define GBFP_ASSERT(lbl, clk, rst, prop)
`define GBFP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/gbfp_pkg.sv
// ----------------------------------------------------------------------------
// gbfp_pkg
// Shared constants and types of the GNSS binary frame parser.
// ----------------------------------------------------------------------------
package gbfp_pkg;

   localparam logic [7:0]  SYNC_FIRST    = 8'hB5;
   localparam logic [7:0]  SYNC_SECOND   = 8'h62;
   localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_BAD_A   = 2'd1;
   localparam logic [1:0] STAT_BAD_B   = 2'd2;
   localparam logic [1:0] STAT_TOO_LONG = 2'd3;

   // input register contents
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } gbfp_stage_type;

   // one result word
   typedef struct packed {
      logic        kind;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] payload_len;
      logic [15:0] byte_index;
      logic [7:0]  data_byte;
      logic [1:0]  status;
   } gbfp_result_type;

   // handshake between the parse step and the two registers
   typedef struct packed {
      logic fire;
      logic emit;
   } gbfp_ctl_type;

endpackage

// File: rtl/core/gbfp_if.sv
// ----------------------------------------------------------------------------
// gbfp channel interfaces
// Valid/ready channels for received bytes, results and the length limit.
// ----------------------------------------------------------------------------
interface gbfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gbfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  msg_class;
   logic [7:0]  msg_id;
   logic [15:0] payload_len;
   logic [15:0] byte_index;
   logic [7:0]  data_byte;
   logic [1:0]  status;

   modport source (output valid, output kind, output msg_class, output msg_id,
                   output payload_len, output byte_index, output data_byte,
                   output status, input ready);
   modport sink   (input valid, input kind, input msg_class, input msg_id,
                   input payload_len, input byte_index, input data_byte,
                   input status, output ready);
endinterface

interface gbfp_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/gbfp_in_reg.sv
// ----------------------------------------------------------------------------
// gbfp_in_reg
// Input register: holds one received word until the parse step takes it.
// ----------------------------------------------------------------------------
module gbfp_in_reg
   import gbfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   gbfp_req_if.sink       req_bus,
   input  logic           pop,
   output gbfp_stage_type stage
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       accept;

   assign req_bus.ready = !valid_ff || pop;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      byte_in  = accept ? req_bus.rx_byte : byte_ff;
      valid_in = accept ? 1'b1 : (pop ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign stage.valid   = valid_ff;
   assign stage.rx_byte = byte_ff;

endmodule

// File: rtl/core/gbfp_core.sv
// ----------------------------------------------------------------------------
// gbfp_core
// Frame state machine, Fletcher sums and length limit register.
// ----------------------------------------------------------------------------
module gbfp_core
   import gbfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   gbfp_csr_if.sink        csr_bus,
   input  gbfp_stage_type  stage,
   input  logic            out_free,
   output gbfp_ctl_type    ctl,
   output gbfp_result_type result
);

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_SYNC1    = 4'd1;
   localparam logic [3:0] PH_CLASS    = 4'd2;
   localparam logic [3:0] PH_ID       = 4'd3;
   localparam logic [3:0] PH_LEN1     = 4'd4;
   localparam logic [3:0] PH_LEN2     = 4'd5;
   localparam logic [3:0] PH_PAYLOAD  = 4'd6;
   localparam logic [3:0] PH_CKA      = 4'd7;
   localparam logic [3:0] PH_CKB_GOOD = 4'd8;
   localparam logic [3:0] PH_CKB_BADA = 4'd9;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] seen_ff, seen_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [15:0] max_len_ff, max_len_in;

   logic [7:0]  b;
   logic [7:0]  add_a, add_b;
   logic [15:0] seen_inc;
   logic        fire, emit;

   assign csr_bus.ready = 1'b1;
   assign max_len_in    = csr_bus.valid ? csr_bus.data : max_len_ff;

   assign b        = stage.rx_byte;
   assign fire     = stage.valid && out_free;
   assign add_a    = sum_a_ff + b;
   assign add_b    = sum_b_ff + add_a;
   assign seen_inc = seen_ff + 16'd1;

   always_comb begin
      phase_in = phase_ff;
      class_in = class_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      seen_in  = seen_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      emit     = 1'b0;
      result.kind       = KIND_PAYLOAD;
      result.byte_index = seen_ff;
      result.data_byte  = 8'd0;
      result.status     = STAT_OK;

      unique case (phase_ff)
         PH_SYNC1: begin
            if (b == SYNC_SECOND) begin
               phase_in = PH_CLASS;
               sum_a_in = 8'd0;
               sum_b_in = 8'd0;
            end else if (b != SYNC_FIRST) begin
               phase_in = PH_IDLE;
            end
         end
         PH_CLASS: begin
            class_in = b;
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_ID;
         end
         PH_ID: begin
            id_in    = b;
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_LEN1;
         end
         PH_LEN1: begin
            len_in   = {8'd0, b};
            sum_a_in = add_a;
            sum_b_in = add_b;
            phase_in = PH_LEN2;
         end
         PH_LEN2: begin
            len_in   = {b, len_ff[7:0]};
            sum_a_in = add_a;
            sum_b_in = add_b;
            seen_in  = 16'd0;
            if (len_in > max_len_ff) begin
               phase_in          = PH_IDLE;
               emit              = 1'b1;
               result.kind       = KIND_END;
               result.byte_index = 16'd0;
               result.status     = STAT_TOO_LONG;
            end else if (len_in == 16'd0) begin
               phase_in = PH_CKA;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sum_a_in         = add_a;
            sum_b_in         = add_b;
            emit             = 1'b1;
            result.data_byte = b;
            seen_in          = seen_inc;
            if (seen_inc == len_ff) begin
               phase_in = PH_CKA;
            end
         end
         PH_CKA: begin
            phase_in = (b == sum_a_ff) ? PH_CKB_GOOD : PH_CKB_BADA;
         end
         PH_CKB_GOOD, PH_CKB_BADA: begin
            phase_in    = PH_IDLE;
            emit        = 1'b1;
            result.kind = KIND_END;
            if (phase_ff == PH_CKB_BADA) begin
               result.status = STAT_BAD_A;
            end else if (b != sum_b_ff) begin
               result.status = STAT_BAD_B;
            end
         end
         // idle, and codes with no meaning
         default: begin
            phase_in = (b == SYNC_FIRST) ? PH_SYNC1 : PH_IDLE;
         end
      endcase

      result.msg_class   = class_in;
      result.msg_id      = id_in;
      result.payload_len = len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         class_ff   <= 8'd0;
         id_ff      <= 8'd0;
         len_ff     <= 16'd0;
         seen_ff    <= 16'd0;
         sum_a_ff   <= 8'd0;
         sum_b_ff   <= 8'd0;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
         if (fire) begin
            phase_ff <= phase_in;
            class_ff <= class_in;
            id_ff    <= id_in;
            len_ff   <= len_in;
            seen_ff  <= seen_in;
            sum_a_ff <= sum_a_in;
            sum_b_ff <= sum_b_in;
         end
      end
   end

   assign ctl.fire = fire;
   assign ctl.emit = emit;

endmodule

// File: rtl/core/gbfp_out_reg.sv
// ----------------------------------------------------------------------------
// gbfp_out_reg
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module gbfp_out_reg
   import gbfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  gbfp_ctl_type    ctl,
   input  gbfp_result_type result,
   output logic            out_free,
   gbfp_rsp_if.source      rsp_bus
);

   logic            valid_ff, valid_in;
   gbfp_result_type data_ff, data_in;
   logic            load;

   assign out_free = !valid_ff || rsp_bus.ready;
   assign load     = ctl.fire && ctl.emit;

   always_comb begin
      data_in  = load ? result : data_ff;
      valid_in = load ? 1'b1 : (rsp_bus.ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.kind        = data_ff.kind;
   assign rsp_bus.msg_class   = data_ff.msg_class;
   assign rsp_bus.msg_id      = data_ff.msg_id;
   assign rsp_bus.payload_len = data_ff.payload_len;
   assign rsp_bus.byte_index  = data_ff.byte_index;
   assign rsp_bus.data_byte   = data_ff.data_byte;
   assign rsp_bus.status      = data_ff.status;

endmodule

// File: rtl/core/gnss_binary_frame_parser.sv
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser
// Sync 0xB5 0x62 frame parser with 8-bit Fletcher checksum check.
// ----------------------------------------------------------------------------
// Takes one received byte per word and sustains one word every cycle while
// the result port is not stalled. A byte lands in the input register when it
// is accepted, and its result word is loaded from there into the result
// register, which drives the result port. A stalled result port holds the
// input register, and with it the input side, until the result drains.
// Payload bytes come out with their index, and each
// frame closes with one end word carrying the status: ok, checksum A bad,
// checksum B bad, or too long (length above the limit register; the rest of
// that frame is then hunted through as plain bytes). The limit register
// resets to 1024 and may be written only while no frame is in flight.
`include "gnss_binary_frame_parser_defines.svh"

module gnss_binary_frame_parser
   import gbfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   gbfp_req_if.sink   req_bus,
   gbfp_rsp_if.source rsp_bus,
   gbfp_csr_if.sink   csr_bus
);

   gbfp_stage_type  stage;
   gbfp_ctl_type    ctl;
   gbfp_result_type result;
   logic            out_free;

   gbfp_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .pop     (ctl.fire),
      .stage   (stage)
   );

   gbfp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .csr_bus  (csr_bus),
      .stage    (stage),
      .out_free (out_free),
      .ctl      (ctl),
      .result   (result)
   );

   gbfp_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .result   (result),
      .out_free (out_free),
      .rsp_bus  (rsp_bus)
   );

   // a held input word must drain in the same cycle a new one lands
   `GBFP_ASSERT(a_in_no_overrun, clock, reset, (req_bus.valid && req_bus.ready) |-> (!stage.valid || ctl.fire))
   // a stalled result is never overwritten
   `GBFP_ASSERT(a_out_no_overwrite, clock, reset, (rsp_bus.valid && !rsp_bus.ready) |-> !(ctl.fire && ctl.emit))
   // every emitted result shows up on the port next cycle
   `GBFP_ASSERT_NEXT(a_emit_shows, clock, reset, ctl.fire && ctl.emit, rsp_bus.valid)
   // payload words stay inside the declared length and carry ok status
   `GBFP_ASSERT(a_payload_index, clock, reset, (rsp_bus.valid && rsp_bus.kind == KIND_PAYLOAD) |-> (rsp_bus.byte_index < rsp_bus.payload_len && rsp_bus.status == STAT_OK))

endmodule

// File: dv/gbfp_frame_checker.sv
// ----------------------------------------------------------------------------
// gbfp_frame_checker
// Watches the byte, result and limit channels of the frame parser, predicts
// every result word from the accepted bytes and compares it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbfp_frame_checker
   import gbfp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   gbfp_req_if  req_mon,
   gbfp_rsp_if  rsp_mon,
   gbfp_csr_if  csr_mon,
   output int   mismatch_count,
   output int   words_awaited,
   output logic parser_mid_frame
);

   typedef enum logic [3:0] {
      HUNT,
      GOT_B5,
      TAKE_CLASS,
      TAKE_ID,
      TAKE_LEN_LO,
      TAKE_LEN_HI,
      TAKE_PAYLOAD,
      TAKE_CK_A,
      TAKE_CK_B,
      TAKE_CK_B_FAILED_A
   } parse_phase_type;

   parse_phase_type phase        = HUNT;
   logic [15:0]     len_limit    = MAX_LEN_RESET;
   logic [7:0]      cur_class    = '0;
   logic [7:0]      cur_id       = '0;
   logic [15:0]     cur_len      = '0;
   logic [15:0]     payload_seen = '0;
   logic [7:0]      fl_a         = '0;
   logic [7:0]      fl_b         = '0;
   gbfp_result_type predicted_words[$];
   int              mismatches   = 0;

   initial begin
      mismatch_count   = 0;
      words_awaited    = 0;
      parser_mid_frame = 1'b0;
   end

   function automatic void fletcher_add(input logic [7:0] b);
      fl_a = fl_a + b;
      fl_b = fl_b + fl_a;
   endfunction

   function automatic gbfp_result_type frame_word(input logic kind, input logic [15:0] idx,
                                                  input logic [7:0] data,
                                                  input logic [1:0] st);
      return '{kind: kind, msg_class: cur_class, msg_id: cur_id, payload_len: cur_len,
               byte_index: idx, data_byte: data, status: st};
   endfunction

   // advances the parse state by one byte; returns 1 when a word comes out
   function automatic bit parse_rx_byte(input logic [7:0] b, output gbfp_result_type word);
      bit made;
      made = 1'b0;
      word = '0;
      case (phase)
         GOT_B5: begin
            if (b == SYNC_SECOND) begin
               phase = TAKE_CLASS;
               fl_a  = '0;
               fl_b  = '0;
            end else if (b != SYNC_FIRST) begin
               phase = HUNT;
            end
         end
         TAKE_CLASS: begin
            cur_class = b;
            fletcher_add(b);
            phase = TAKE_ID;
         end
         TAKE_ID: begin
            cur_id = b;
            fletcher_add(b);
            phase = TAKE_LEN_LO;
         end
         TAKE_LEN_LO: begin
            cur_len = {8'h00, b};
            fletcher_add(b);
            phase = TAKE_LEN_HI;
         end
         TAKE_LEN_HI: begin
            cur_len = {b, cur_len[7:0]};
            fletcher_add(b);
            payload_seen = '0;
            if (cur_len > len_limit) begin
               phase = HUNT;
               word  = frame_word(KIND_END, 16'd0, 8'd0, STAT_TOO_LONG);
               made  = 1'b1;
            end else begin
               phase = (cur_len == 16'd0) ? TAKE_CK_A : TAKE_PAYLOAD;
            end
         end
         TAKE_PAYLOAD: begin
            fletcher_add(b);
            word = frame_word(KIND_PAYLOAD, payload_seen, b, STAT_OK);
            made = 1'b1;
            payload_seen = payload_seen + 16'd1;
            if (payload_seen == cur_len)
               phase = TAKE_CK_A;
         end
         TAKE_CK_A: begin
            phase = (b == fl_a) ? TAKE_CK_B : TAKE_CK_B_FAILED_A;
         end
         TAKE_CK_B, TAKE_CK_B_FAILED_A: begin
            // a bad A wins over whatever B holds
            if (phase == TAKE_CK_B_FAILED_A)
               word = frame_word(KIND_END, payload_seen, 8'd0, STAT_BAD_A);
            else if (b != fl_b)
               word = frame_word(KIND_END, payload_seen, 8'd0, STAT_BAD_B);
            else
               word = frame_word(KIND_END, payload_seen, 8'd0, STAT_OK);
            phase = HUNT;
            made  = 1'b1;
         end
         default: begin
            phase = (b == SYNC_FIRST) ? GOT_B5 : HUNT;
         end
      endcase
      return made;
   endfunction

   task automatic report_mismatch(input bit orphan, input gbfp_result_type want,
                                  input gbfp_result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         if (orphan)
            $display("%0t gbfp check: result word with nothing predicted", $time);
         else
            $display("%0t gbfp check: mismatch, expected kind=%0d class=%02h id=%02h len=%0d idx=%0d data=%02h status=%0d",
                     $time, want.kind, want.msg_class, want.msg_id, want.payload_len,
                     want.byte_index, want.data_byte, want.status);
         $display("%0t gbfp check:   actual   kind=%0d class=%02h id=%02h len=%0d idx=%0d data=%02h status=%0d",
                  $time, got.kind, got.msg_class, got.msg_id, got.payload_len,
                  got.byte_index, got.data_byte, got.status);
      end
   endtask

   always @(posedge clock) begin : watch
      gbfp_result_type got_word;
      gbfp_result_type want_word;
      gbfp_result_type next_word;
      if (reset) begin
         phase        = HUNT;
         len_limit    = MAX_LEN_RESET;
         cur_class    = '0;
         cur_id       = '0;
         cur_len      = '0;
         payload_seen = '0;
         fl_a         = '0;
         fl_b         = '0;
         predicted_words.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_word = '{kind: rsp_mon.kind, msg_class: rsp_mon.msg_class,
                         msg_id: rsp_mon.msg_id, payload_len: rsp_mon.payload_len,
                         byte_index: rsp_mon.byte_index, data_byte: rsp_mon.data_byte,
                         status: rsp_mon.status};
            if (predicted_words.size() == 0) begin
               report_mismatch(1'b1, '0, got_word);
            end else begin
               want_word = predicted_words.pop_front();
               if (got_word !== want_word)
                  report_mismatch(1'b0, want_word, got_word);
            end
         end
         if (csr_mon.valid && csr_mon.ready)
            len_limit = csr_mon.data;
         if (req_mon.valid && req_mon.ready) begin
            if (parse_rx_byte(req_mon.rx_byte, next_word))
               predicted_words.push_back(next_word);
         end
      end
      mismatch_count   <= mismatches;
      words_awaited    <= predicted_words.size();
      parser_mid_frame <= (phase != HUNT);
   end

endmodule

// File: dv/gnss_binary_frame_parser_test.sv
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser_test
// Feeds the frame parser directed corner cases and then random frames, good,
// corrupted and cut short, mixed with line noise, under several length limits,
// with bursty input and a stalling result side. The checker does the scoring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gnss_binary_frame_parser_test;
   import gbfp_pkg::*;

   typedef enum int {FRAME_CLEAN, FRAME_BAD_A, FRAME_BAD_B, FRAME_CUT} frame_fault_type;

   logic        clock;
   logic        reset;
   int          mismatch_count;
   int          words_awaited;
   logic        parser_mid_frame;
   int          burst_left;
   int          bytes_sent;
   logic [15:0] cur_limit;

   gbfp_req_if req_bus ();
   gbfp_rsp_if rsp_bus ();
   gbfp_csr_if csr_bus ();

   gnss_binary_frame_parser u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   gbfp_frame_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_mon          (csr_bus),
      .mismatch_count   (mismatch_count),
      .words_awaited    (words_awaited),
      .parser_mid_frame (parser_mid_frame)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   initial begin
      #2_000_000;
      $display("gnss_binary_frame_parser_test: done, errors");
      $finish;
   end

   // result side: a stall mode that changes every so often
   initial begin : rsp_stall
      int mode;
      int mode_left;
      int tick;
      mode_left = 0;
      tick      = 0;
      mode      = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 200);
         end
         mode_left--;
         tick++;
         case (mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_bus.ready <= ((tick % 5) != 4);
            default: rsp_bus.ready <= ($urandom_range(0, 11) == 0);
         endcase
      end
   end

   // sync bytes show up inside payloads fairly often
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return SYNC_FIRST;
         1: return SYNC_SECOND;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic push_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                  : $urandom_range(1, 12);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      bytes_sent++;
   endtask

   // zero bytes until the parser hunts again; a half header then closes
   // with a short length instead of swallowing the next frames
   task automatic flush_parser();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (parser_mid_frame) begin
         push_byte(8'h00);
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input frame_fault_type fault);
      logic [7:0] body[$];
      logic [7:0] fa;
      logic [7:0] fb;
      logic [7:0] flip;
      int         keep;
      body.push_back(cls);
      body.push_back(id);
      body.push_back(len[7:0]);
      body.push_back(len[15:8]);
      fa   = '0;
      fb   = '0;
      flip = 8'($urandom_range(1, 255));
      if (len > cur_limit) begin
         // the rest of an overlong frame is just line traffic to the parser
         repeat ($urandom_range(0, 4)) body.push_back(pick_byte());
      end else begin
         for (int i = 0; i < len; i++) body.push_back(pick_byte());
         foreach (body[k]) begin
            fa = fa + body[k];
            fb = fb + fa;
         end
         body.push_back((fault == FRAME_BAD_A) ? fa ^ flip : fa);
         body.push_back((fault == FRAME_BAD_A) ? 8'($urandom) :
                        (fault == FRAME_BAD_B) ? fb ^ flip : fb);
      end
      keep = body.size();
      if (fault == FRAME_CUT)
         keep = $urandom_range(0, body.size() - 1);
      push_byte(SYNC_FIRST);
      push_byte(SYNC_SECOND);
      for (int k = 0; k < keep; k++) push_byte(body[k]);
      if (fault == FRAME_CUT || len > cur_limit)
         flush_parser();
   endtask

   // brings the parser back to hunting and lets all results drain
   task automatic settle_parser();
      flush_parser();
      while (words_awaited != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] v);
      settle_parser();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      cur_limit = v;
   endtask

   initial begin : stimulus
      logic [15:0] limit_plan[$];
      logic [15:0] len;
      int          target;
      frame_fault_type fault;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      csr_bus.valid   <= 1'b0;
      csr_bus.data    <= 16'h0000;
      burst_left = 0;
      bytes_sent = 0;
      cur_limit  = MAX_LEN_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // broken sync, repeated B5, then zero length with bad B
      push_byte(SYNC_FIRST);
      push_byte(8'h00);
      push_byte(SYNC_FIRST);
      send_frame(8'hFF, 8'h00, 16'd0, FRAME_BAD_B);
      send_frame(8'h00, 8'hFF, 16'd1, FRAME_BAD_A);
      send_frame(8'h80, 8'h01, 16'hFFFF, FRAME_CLEAN);
      send_frame(8'h7F, 8'hFE, 16'd2, FRAME_CLEAN);

      limit_plan.push_back(16'd0);
      limit_plan.push_back(16'hFFFF);
      limit_plan.push_back(16'd1);
      limit_plan.push_back(16'($urandom_range(2, 63)));
      limit_plan.push_back(16'($urandom));
      limit_plan.push_back(MAX_LEN_RESET);

      foreach (limit_plan[p]) begin
         write_limit(limit_plan[p]);
         target = bytes_sent + 135;
         while (bytes_sent < target) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: len = 16'($urandom_range(0, 12));
               6: len = 16'd0;
               7: len = (cur_limit <= 16'd64) ? cur_limit : 16'($urandom_range(13, 64));
               8: len = (cur_limit != 16'hFFFF) ? cur_limit + 16'd1
                                                : 16'($urandom_range(0, 12));
               default: len = (cur_limit != 16'hFFFF)
                              ? 16'($urandom_range(cur_limit + 1, 65535)) : 16'd0;
            endcase
            case ($urandom_range(0, 11))
               0: fault = FRAME_BAD_A;
               1: fault = FRAME_BAD_B;
               2: fault = FRAME_CUT;
               default: fault = FRAME_CLEAN;
            endcase
            if ($urandom_range(0, 5) == 0) begin
               repeat ($urandom_range(1, 4)) push_byte(pick_byte());
               flush_parser();
            end else begin
               send_frame(8'($urandom), 8'($urandom), len, fault);
            end
         end
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (words_awaited != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (mismatch_count == 0)
         $display("gnss_binary_frame_parser_test: done, clean");
      else
         $display("gnss_binary_frame_parser_test: done, errors");
      $finish;
   end

endmodule

// File: gnss_binary_frame_parser.f
+incdir+rtl/core
rtl/core/gbfp_pkg.sv
rtl/core/gbfp_if.sv
rtl/core/gbfp_in_reg.sv
rtl/core/gbfp_core.sv
rtl/core/gbfp_out_reg.sv
rtl/core/gnss_binary_frame_parser.sv
dv/gbfp_frame_checker.sv
dv/gnss_binary_frame_parser_test.sv
